FILE: design/chr_pkg.sv
// Shared types, constants and arithmetic helpers of the cubic Hermite resampler.
`default_nettype none
package chr_pkg;
  localparam int SLOTS       = 4;
  localparam int FRAC_BITS   = 16;
  localparam int MAX_OUTPUTS = 64;
  localparam int LANE_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int PHASE_W     = FRAC_BITS + 5;
  localparam int RATE_W      = 20;
  localparam int CNT_W       = $clog2(MAX_OUTPUTS + 1);
  localparam int SAT_LIMIT   = 32767;

  localparam logic [1:0] PICK_LEFT  = 2'd1;
  localparam logic [1:0] PICK_RIGHT = 2'd2;

  typedef struct packed {
    logic signed [15:0]   oldest;
    logic signed [15:0]   current;
    logic signed [15:0]   next;
    logic signed [15:0]   newest;
    logic [PHASE_W-1:0]   phase;
    logic                 needs_prime;
    logic [1:0]           prime_count;
  } lane_state_t;

  // Reset value of one lane entry.
  function automatic lane_state_t lane_reset();
    lane_state_t s;
    s = '0;
    s.needs_prime = 1'b1;
    return s;
  endfunction

  // Signed product scaled down by 2^FRAC_BITS, truncated toward zero.
  function automatic logic signed [31:0] scale_trunc(input logic signed [47:0] prod);
    logic signed [47:0] adj;
    adj = prod;
    if (prod[47]) adj = prod + ((48'sd1 <<< FRAC_BITS) - 48'sd1);
    return 32'(adj >>> FRAC_BITS);
  endfunction
endpackage
`default_nettype wire

FILE: design/chr_state_mem.sv
// Lane state memory with one registered read port and one write port.
`default_nettype none
module chr_state_mem (
  input  wire logic                        clk,
  input  wire logic                        rd_en,
  input  wire logic [chr_pkg::LANE_W-1:0]  rd_addr,
  output chr_pkg::lane_state_t             rd_data,
  input  wire logic                        wr_en,
  input  wire logic [chr_pkg::LANE_W-1:0]  wr_addr,
  input  wire chr_pkg::lane_state_t        wr_data
);
  chr_pkg::lane_state_t mem [chr_pkg::SLOTS];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

FILE: design/chr_interp.sv
// Three-step cubic Hermite evaluation, one multiply per step, then clamp.
`default_nettype none
module chr_interp (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire chr_pkg::lane_state_t          win,
  output logic                               done,
  output logic signed [15:0]                 result
);
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001, S_ONE = 4'b0010, S_TWO = 4'b0100, S_THREE = 4'b1000
  } ip_state_t;

  ip_state_t state_r, state_nxt;
  logic signed [31:0] acc_r, acc_nxt;
  logic signed [31:0] cb_r, cc_r, x02_r;
  logic [chr_pkg::PHASE_W-1:0] p_r;
  logic signed [31:0] m, x0, x1, x2, ca, scaled, w, y;
  logic signed [47:0] prod;
  logic done_nxt;

  assign m  = 32'(win.oldest);
  assign x0 = 32'(win.current);
  assign x1 = 32'(win.next);
  assign x2 = 32'(win.newest);
  assign ca = 3 * (x0 - x1) - m + x2;

  assign prod   = 48'(acc_r) * 48'($signed({1'b0, p_r}));
  assign scaled = chr_pkg::scale_trunc(prod);

  always_comb begin
    state_nxt = state_r;
    acc_nxt   = acc_r;
    done_nxt  = 1'b0;
    w = scaled + x02_r;
    y = (w < 0) ? -((-w) >>> 1) : (w >>> 1);
    unique case (state_r)
      S_IDLE:  if (start) begin acc_nxt = ca; state_nxt = S_ONE; end
      S_ONE:   begin acc_nxt = scaled + cb_r; state_nxt = S_TWO; end
      S_TWO:   begin acc_nxt = scaled + cc_r; state_nxt = S_THREE; end
      S_THREE: begin
        acc_nxt = y; done_nxt = 1'b1; state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done    <= done_nxt;
    end
    acc_r <= acc_nxt;
    if (state_r == S_IDLE && start) begin
      cb_r  <= 4 * x1 + 2 * m - 5 * x0 - x2;
      cc_r  <= x1 - m;
      x02_r <= 2 * x0;
      p_r   <= win.phase;
    end
  end

  always_comb begin
    if (acc_r > chr_pkg::SAT_LIMIT)       result = 16'sd32767;
    else if (acc_r < -chr_pkg::SAT_LIMIT) result = -16'sd32767;
    else                                  result = 16'(acc_r);
  end
endmodule
`default_nettype wire

FILE: design/chr_ctrl.sv
// Per-item sequencer: read lane state, prime or shift, emit outputs, write back.
`default_nettype none
module chr_ctrl (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [55:0]  in_tdata,
  input  wire logic         in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [15:0]       out_tdata,
  output logic              out_tlast
);
  typedef enum logic [6:0] {
    C_CLEAR = 7'b0000001, C_IDLE = 7'b0000010, C_READ = 7'b0000100,
    C_EVAL  = 7'b0001000, C_WAIT = 7'b0010000, C_EMIT = 7'b0100000,
    C_WB    = 7'b1000000
  } ctrl_state_t;

  localparam logic [chr_pkg::PHASE_W-1:0] ONE_POS = chr_pkg::PHASE_W'(1) << chr_pkg::FRAC_BITS;

  ctrl_state_t state_r, state_nxt;
  logic [chr_pkg::LANE_W-1:0]  lane_r, clr_r;
  logic signed [15:0]          smp_r;
  logic [chr_pkg::RATE_W-1:0]  rate_r;
  logic                        restart_r, bypass_r;
  chr_pkg::lane_state_t        st_r, st_nxt, st_byp, rd_data, wr_data;
  logic [chr_pkg::CNT_W-1:0]   n_r;
  logic                        ovalid_r, olast_r;
  logic [15:0]                 odata_r;
  logic                        rd_en, wr_en, ip_done;
  logic [chr_pkg::LANE_W-1:0]  wr_addr;
  logic signed [15:0]          ip_res;
  logic                        ip_start;
  logic [chr_pkg::PHASE_W:0]   phase_sum;

  logic [1:0]         pk;
  logic signed [15:0] lo, hi, pick_smp;
  logic signed [16:0] sum;
  logic [1:0]         lane_raw;
  assign pk  = in_tdata[2:1];
  assign lo  = in_tdata[18:3];
  assign hi  = in_tdata[34:19];
  assign sum = 17'(lo) + 17'(hi);
  always_comb begin
    case (pk)
      chr_pkg::PICK_LEFT:  pick_smp = lo;
      chr_pkg::PICK_RIGHT: pick_smp = hi;
      default:             pick_smp = sum[16:1];
    endcase
  end
  assign lane_raw = {in_tdata[0], pk == chr_pkg::PICK_RIGHT};

  assign in_tready = (state_r == C_IDLE);
  assign rd_en     = (state_r == C_IDLE) && in_tvalid;
  assign ip_start  = (state_r == C_EVAL);
  assign wr_en     = (state_r == C_CLEAR) || (state_r == C_WB);
  assign wr_addr   = (state_r == C_CLEAR) ? clr_r : lane_r;
  assign wr_data   = (state_r == C_CLEAR) ? chr_pkg::lane_reset() : st_r;
  assign phase_sum = {1'b0, st_r.phase} + (chr_pkg::PHASE_W + 1)'(rate_r);

  chr_state_mem u_mem (
    .clk(clk), .rd_en(rd_en), .rd_addr(chr_pkg::LANE_W'(lane_raw % chr_pkg::SLOTS)),
    .rd_data(rd_data), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data)
  );

  chr_interp u_interp (
    .clk(clk), .rst_n(rst_n), .start(ip_start), .win(st_r),
    .done(ip_done), .result(ip_res)
  );

  // A bypass keeps the window and phase and only marks the lane for priming.
  always_comb begin
    st_byp = rd_data;
    st_byp.needs_prime = 1'b1;
    st_byp.prime_count = 2'd0;
  end

  // Prime/shift update of the lane just read.
  always_comb begin
    st_nxt = rd_data;
    if (restart_r) begin
      st_nxt.needs_prime = 1'b1;
      st_nxt.prime_count = 2'd0;
    end
    if (st_nxt.needs_prime) begin
      case (st_nxt.prime_count)
        2'd0:    begin st_nxt.current = smp_r; st_nxt.prime_count = 2'd1; end
        2'd1:    begin st_nxt.next = smp_r; st_nxt.prime_count = 2'd2; end
        default: begin
          st_nxt.newest = smp_r; st_nxt.prime_count = 2'd0;
          st_nxt.needs_prime = 1'b0; st_nxt.phase = '0;
        end
      endcase
    end else begin
      st_nxt.oldest  = rd_data.current;
      st_nxt.current = rd_data.next;
      st_nxt.next    = rd_data.newest;
      st_nxt.newest  = smp_r;
      st_nxt.phase   = (rd_data.phase >= ONE_POS) ? rd_data.phase - ONE_POS : '0;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      C_CLEAR: if (clr_r == chr_pkg::LANE_W'(chr_pkg::SLOTS - 1)) state_nxt = C_IDLE;
      C_IDLE:  if (in_tvalid) state_nxt = C_READ;
      C_READ:  begin
        if (bypass_r) state_nxt = C_EMIT;
        else if (st_nxt.needs_prime) state_nxt = C_WB;
        else if (st_nxt.phase < ONE_POS) state_nxt = C_EVAL;
        else state_nxt = C_WB;
      end
      C_EVAL:  state_nxt = C_WAIT;
      C_WAIT:  if (ip_done) state_nxt = C_EMIT;
      C_EMIT:  begin
        if (!ovalid_r || out_tready) begin
          if (bypass_r) state_nxt = C_WB;
          else if (phase_sum < (chr_pkg::PHASE_W + 1)'(ONE_POS)
                   && n_r < chr_pkg::CNT_W'(chr_pkg::MAX_OUTPUTS - 1)) state_nxt = C_EVAL;
          else state_nxt = C_WB;
        end
      end
      C_WB:    state_nxt = C_IDLE;
      default: state_nxt = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= C_CLEAR;
      clr_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == C_CLEAR) clr_r <= clr_r + 1'b1;
      if (state_r == C_EMIT && (!ovalid_r || out_tready)) ovalid_r <= 1'b1;
      else if (out_tready) ovalid_r <= 1'b0;
    end
    if (state_r == C_IDLE && in_tvalid) begin
      lane_r    <= chr_pkg::LANE_W'(lane_raw % chr_pkg::SLOTS);
      smp_r     <= pick_smp;
      rate_r    <= in_tdata[54:35];
      restart_r <= in_tuser;
      bypass_r  <= (in_tdata[54:35] == chr_pkg::RATE_W'(ONE_POS));
      n_r       <= '0;
    end
    if (state_r == C_READ) begin
      st_r <= bypass_r ? st_byp : st_nxt;
    end
    if (state_r == C_EMIT && (!ovalid_r || out_tready)) begin
      if (bypass_r) begin
        odata_r <= smp_r;
        olast_r <= 1'b1;
      end else begin
        odata_r <= ip_res;
        olast_r <= !(phase_sum < (chr_pkg::PHASE_W + 1)'(ONE_POS)
                     && n_r < chr_pkg::CNT_W'(chr_pkg::MAX_OUTPUTS - 1));
        st_r.phase <= phase_sum[chr_pkg::PHASE_W-1:0];
        n_r <= n_r + 1'b1;
      end
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
  assign out_tlast  = olast_r;
endmodule
`default_nettype wire

FILE: design/cubic_hermite_resampler.sv
// Top level of the four-point cubic Hermite resampler.
//
//   channel | direction | tdata (low bit up)                         | tuser   | tlast
//   in_     | slave     | channel, pick, source_word, rate, 0 pad    | restart | -
//   out_    | master    | sample                                     | -       | last_of_run
//
// An item that only primes its lane goes through read, update and write back before
// the next acceptance; a unity-rate bypass word also loads the output register before
// write back. An item that interpolates, for each output word, starts the shared
// evaluator, waits for its three dependent multiplies and the registered done, and
// loads the output register, up to the cap of 64 words. After reset a sweep over all
// SLOTS lane entries clears the lane memory; in_tready stays low during it. Reset is
// synchronous and active low. A stalled output word holds the sequencer; a new input
// word is taken only once the previous one is finished.
`default_nettype none
module cubic_hermite_resampler (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [55:0]  in_tdata,   // channel, pick[1:0], source_word[31:0], rate[19:0]
  input  wire logic         in_tuser,   // restart
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [15:0]       out_tdata,  // sample
  output logic              out_tlast
);
  // The sequencer owns the lane memory and the evaluator.
  chr_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );
endmodule
`default_nettype wire

FILE: design/chr_checker.sv
// Port-level checks of the resampler, bound to the top level.
`default_nettype none
module chr_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [15:0] out_tdata,
  input wire logic        out_tlast
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output word changed while stalled");
  a_no_accept_after: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken on back-to-back cycles");
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && !in_tready)
    else $error("ports not quiet after reset");
endmodule

bind cubic_hermite_resampler chr_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
  .out_tlast(out_tlast)
);
`default_nettype wire
